@@ rtl/stbg_pkg.sv @@
// ============================================================================
// stbg_pkg
// Shared types, constants and the quarter-wave sine table for the sine tone
// generator with biquad filter.
// ============================================================================
package stbg_pkg;

    localparam int SINE_TABLE_BITS = 10;
    localparam int SINE_DEPTH      = 1 << SINE_TABLE_BITS;
    localparam int COEF_FRAC_BITS  = 27;

    localparam int PHASE_W  = 32;
    localparam int STEP_W   = 31;
    localparam int AMP_W    = 16;
    localparam int COEF_W   = 32;
    localparam int ENTRY_W  = 15;
    localparam int X_W      = 24;
    localparam int Y_W      = 28;
    localparam int PROD_W   = COEF_W + Y_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = 3;

    localparam logic [AMP_W-1:0] AMP_FULL = 16'd32768;
    localparam longint SAT_LIMIT = longint'(1) << 26;
    localparam longint ONE_Q23   = longint'(1) << 23;

    typedef enum logic [IDX_W-1:0] {
        CFG_PHASE_STEP = 3'd0,
        CFG_TONE_AMP   = 3'd1,
        CFG_EQ_ENABLE  = 3'd2,
        CFG_COEF_B0    = 3'd3,
        CFG_COEF_B1    = 3'd4,
        CFG_COEF_B2    = 3'd5,
        CFG_COEF_A1    = 3'd6,
        CFG_COEF_A2    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [STEP_W-1:0]        phase_step;
        logic [AMP_W-1:0]         tone_amplitude;
        logic                     eq_enable;
        logic signed [COEF_W-1:0] coef_b0;
        logic signed [COEF_W-1:0] coef_b1;
        logic signed [COEF_W-1:0] coef_b2;
        logic signed [COEF_W-1:0] coef_a1;
        logic signed [COEF_W-1:0] coef_a2;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_TONE,
        S_XFORM,
        S_MAC_B2,
        S_MAC_A1,
        S_MAC_A2,
        S_MAC_B0,
        S_MAC_END,
        S_FILT,
        S_SCALE
    } state_t;

    typedef enum logic [2:0] {
        MUL_TONE,
        MUL_B0,
        MUL_B1,
        MUL_B2,
        MUL_A1,
        MUL_A2
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef struct packed {
        logic     accept;
        logic     lookup;
        logic     make_x;
        logic     filt;
        logic     load_out;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
    } cmd_t;

    typedef struct packed {
        logic eq_on;
        logic out_busy;
    } sts_t;

    typedef logic [ENTRY_W-1:0] sine_lut_t [SINE_DEPTH];

    // Quarter-wave entry k in unsigned Q0.15 from a Q2.30 series
    function automatic logic [ENTRY_W-1:0] sine_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        logic [63:0] r;
        x = (64'd1686629713 * (64'(k) * 64'd2 + 64'd1) + (64'd1 << SINE_TABLE_BITS))
            >> (SINE_TABLE_BITS + 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        r = (64'(sum) * 64'd32768 + (64'd1 << 29)) >> 30;
        if (r > 64'd32767)
        begin
            return 15'h7fff;
        end
        return r[ENTRY_W-1:0];
    endfunction

    function automatic sine_lut_t build_sine_lut();
        sine_lut_t t;
        for (int k = 0; k < SINE_DEPTH; k++)
        begin
            t[k] = sine_entry(k);
        end
        return t;
    endfunction

    localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

@@ rtl/stbg_regs.sv @@
// ============================================================================
// stbg_regs
// Configuration register file: phase step, amplitude, filter enable and
// the five biquad coefficients.
// ============================================================================
module stbg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [stbg_pkg::IDX_W-1:0]    cfg_index,
    input  logic [stbg_pkg::COEF_W-1:0]   cfg_data,
    output stbg_pkg::cfg_t                cfg
);

    stbg_pkg::cfg_t             cfg_reg;
    stbg_pkg::cfg_t             cfg_next;
    logic [stbg_pkg::AMP_W-1:0] amp_in;

    assign cfg_ready = 1'b1;
    assign amp_in    = cfg_data[stbg_pkg::AMP_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (stbg_pkg::cfg_idx_t'(cfg_index))
                stbg_pkg::CFG_PHASE_STEP: cfg_next.phase_step = cfg_data[stbg_pkg::STEP_W-1:0];
                stbg_pkg::CFG_TONE_AMP:
                begin
                    cfg_next.tone_amplitude = (amp_in > stbg_pkg::AMP_FULL)
                                              ? stbg_pkg::AMP_FULL : amp_in;
                end
                stbg_pkg::CFG_EQ_ENABLE:  cfg_next.eq_enable = cfg_data[0];
                stbg_pkg::CFG_COEF_B0:    cfg_next.coef_b0 = $signed(cfg_data);
                stbg_pkg::CFG_COEF_B1:    cfg_next.coef_b1 = $signed(cfg_data);
                stbg_pkg::CFG_COEF_B2:    cfg_next.coef_b2 = $signed(cfg_data);
                stbg_pkg::CFG_COEF_A1:    cfg_next.coef_a1 = $signed(cfg_data);
                stbg_pkg::CFG_COEF_A2:    cfg_next.coef_a2 = $signed(cfg_data);
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_step     <= '0;
            cfg_reg.tone_amplitude <= 16'd29196;
            cfg_reg.eq_enable      <= 1'b0;
            cfg_reg.coef_b0        <= 32'sd1 <<< stbg_pkg::COEF_FRAC_BITS;
            cfg_reg.coef_b1        <= '0;
            cfg_reg.coef_b2        <= '0;
            cfg_reg.coef_a1        <= '0;
            cfg_reg.coef_a2        <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/stbg_ctrl.sv @@
// ============================================================================
// stbg_ctrl
// Sequencer: steps one sample through table lookup, tone scaling, the five
// shared-multiplier filter products (filter on only) and output scaling.
// ============================================================================
module stbg_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  stbg_pkg::sts_t sts,
    output stbg_pkg::cmd_t cmd
);

    stbg_pkg::state_t state_reg;
    stbg_pkg::state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stbg_pkg::S_IDLE:    if (in_valid) state_next = stbg_pkg::S_LOOKUP;
            stbg_pkg::S_LOOKUP:  state_next = stbg_pkg::S_TONE;
            stbg_pkg::S_TONE:    state_next = stbg_pkg::S_XFORM;
            stbg_pkg::S_XFORM:   state_next = sts.eq_on ? stbg_pkg::S_MAC_B2 : stbg_pkg::S_SCALE;
            stbg_pkg::S_MAC_B2:  state_next = stbg_pkg::S_MAC_A1;
            stbg_pkg::S_MAC_A1:  state_next = stbg_pkg::S_MAC_A2;
            stbg_pkg::S_MAC_A2:  state_next = stbg_pkg::S_MAC_B0;
            stbg_pkg::S_MAC_B0:  state_next = stbg_pkg::S_MAC_END;
            stbg_pkg::S_MAC_END: state_next = stbg_pkg::S_FILT;
            stbg_pkg::S_FILT:    state_next = stbg_pkg::S_SCALE;
            stbg_pkg::S_SCALE:   if (!sts.out_busy) state_next = stbg_pkg::S_IDLE;
            default:             state_next = stbg_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = stbg_pkg::MUL_TONE;
        cmd.acc_op  = stbg_pkg::ACC_HOLD;
        case (state_reg)
            stbg_pkg::S_IDLE:    cmd.accept = in_valid;
            stbg_pkg::S_LOOKUP:  cmd.lookup = 1'b1;
            stbg_pkg::S_TONE:    cmd.mul_sel = stbg_pkg::MUL_TONE;
            stbg_pkg::S_XFORM:
            begin
                cmd.make_x  = 1'b1;
                cmd.mul_sel = stbg_pkg::MUL_B1;
                cmd.acc_op  = stbg_pkg::ACC_CLEAR;
            end
            stbg_pkg::S_MAC_B2:
            begin
                cmd.mul_sel = stbg_pkg::MUL_B2;
                cmd.acc_op  = stbg_pkg::ACC_ADD;
            end
            stbg_pkg::S_MAC_A1:
            begin
                cmd.mul_sel = stbg_pkg::MUL_A1;
                cmd.acc_op  = stbg_pkg::ACC_ADD;
            end
            stbg_pkg::S_MAC_A2:
            begin
                cmd.mul_sel = stbg_pkg::MUL_A2;
                cmd.acc_op  = stbg_pkg::ACC_SUB;
            end
            stbg_pkg::S_MAC_B0:
            begin
                cmd.mul_sel = stbg_pkg::MUL_B0;
                cmd.acc_op  = stbg_pkg::ACC_SUB;
            end
            stbg_pkg::S_MAC_END: cmd.acc_op = stbg_pkg::ACC_ADD;
            stbg_pkg::S_FILT:    cmd.filt = 1'b1;
            stbg_pkg::S_SCALE:   cmd.load_out = !sts.out_busy;
            default:             cmd = cmd;
        endcase
    end

    assign in_stall = (state_reg != stbg_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stbg_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/stbg_dp.sv @@
// ============================================================================
// stbg_dp
// Datapath: phase accumulator, sine table, one shared signed multiplier
// with accumulator, filter history, output scaling and output register.
// ============================================================================
module stbg_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  stbg_pkg::cfg_t                      cfg,
    input  stbg_pkg::cmd_t                      cmd,
    output stbg_pkg::sts_t                      sts,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [stbg_pkg::SAMPLE_W-1:0] sample
);

    localparam int TB    = stbg_pkg::SINE_TABLE_BITS;
    localparam int ACC_W = stbg_pkg::ACC_W;
    localparam int V_W   = 25;
    localparam int T_W   = V_W + 15;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(stbg_pkg::SAT_LIMIT);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI;
    localparam logic signed [stbg_pkg::Y_W-1:0] ONE_HI = stbg_pkg::Y_W'(stbg_pkg::ONE_Q23);
    localparam logic signed [stbg_pkg::Y_W-1:0] ONE_LO = -ONE_HI;
    localparam logic signed [T_W-1:0] ROUND_BIAS = T_W'(stbg_pkg::ONE_Q23 - 1);

    logic [stbg_pkg::PHASE_W-1:0]            phase_reg;
    logic signed [stbg_pkg::X_W-1:0]         in_hist_one_reg;
    logic signed [stbg_pkg::X_W-1:0]         in_hist_two_reg;
    logic signed [stbg_pkg::Y_W-1:0]         out_hist_one_reg;
    logic signed [stbg_pkg::Y_W-1:0]         out_hist_two_reg;
    logic                                    out_valid_reg;

    logic [stbg_pkg::ENTRY_W-1:0]            entry_reg;
    logic                                    neg_reg;
    logic                                    tone_on_reg;
    logic signed [stbg_pkg::PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]                 acc_reg;
    logic signed [stbg_pkg::X_W-1:0]         x_reg;
    logic signed [stbg_pkg::SAMPLE_W-1:0]    sample_reg;

    logic [TB-1:0]                           idx;
    logic signed [stbg_pkg::COEF_W-1:0]      mul_a;
    logic signed [stbg_pkg::Y_W-1:0]         mul_b;
    logic signed [ACC_W-1:0]                 prod_ext;
    logic [stbg_pkg::X_W-1:0]                mag;
    logic signed [stbg_pkg::X_W-1:0]         x_next;
    logic signed [ACC_W-1:0]                 y_shift;
    logic signed [stbg_pkg::Y_W-1:0]         y_sat;
    logic signed [stbg_pkg::Y_W-1:0]         v_pre;
    logic signed [V_W-1:0]                   v_clamp;
    logic signed [T_W-1:0]                   t_mul;
    logic signed [T_W-1:0]                   t_bias;
    logic signed [T_W-1:0]                   t_quot;
    logic signed [stbg_pkg::SAMPLE_W-1:0]    sample_next;

    // table address, mirrored in odd quadrants
    assign idx = phase_reg[stbg_pkg::PHASE_W-3 -: TB] ^ {TB{phase_reg[stbg_pkg::PHASE_W-2]}};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            stbg_pkg::MUL_TONE:
            begin
                mul_a = $signed({{(stbg_pkg::COEF_W-stbg_pkg::AMP_W){1'b0}}, cfg.tone_amplitude});
                mul_b = $signed({{(stbg_pkg::Y_W-stbg_pkg::ENTRY_W){1'b0}}, entry_reg});
            end
            stbg_pkg::MUL_B0:
            begin
                mul_a = cfg.coef_b0;
                mul_b = stbg_pkg::Y_W'(x_reg);
            end
            stbg_pkg::MUL_B1:
            begin
                mul_a = cfg.coef_b1;
                mul_b = stbg_pkg::Y_W'(in_hist_one_reg);
            end
            stbg_pkg::MUL_B2:
            begin
                mul_a = cfg.coef_b2;
                mul_b = stbg_pkg::Y_W'(in_hist_two_reg);
            end
            stbg_pkg::MUL_A1:
            begin
                mul_a = cfg.coef_a1;
                mul_b = out_hist_one_reg;
            end
            stbg_pkg::MUL_A2:
            begin
                mul_a = cfg.coef_a2;
                mul_b = out_hist_two_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_ext = ACC_W'(prod_reg);
    assign mag      = prod_reg[stbg_pkg::X_W+6:7];
    assign x_next   = !tone_on_reg ? '0
                    : (neg_reg ? -$signed(mag) : $signed(mag));

    // floor shift and saturation to +/-8.0
    assign y_shift = acc_reg >>> stbg_pkg::COEF_FRAC_BITS;
    always_comb
    begin
        if (y_shift > SAT_HI)
        begin
            y_sat = SAT_HI[stbg_pkg::Y_W-1:0];
        end
        else if (y_shift < SAT_LO)
        begin
            y_sat = SAT_LO[stbg_pkg::Y_W-1:0];
        end
        else
        begin
            y_sat = y_shift[stbg_pkg::Y_W-1:0];
        end
    end

    // clamp to +/-1.0, scale by 32767, truncate toward zero
    assign v_pre = cfg.eq_enable ? out_hist_one_reg : stbg_pkg::Y_W'(x_reg);
    always_comb
    begin
        if (v_pre > ONE_HI)
        begin
            v_clamp = ONE_HI[V_W-1:0];
        end
        else if (v_pre < ONE_LO)
        begin
            v_clamp = ONE_LO[V_W-1:0];
        end
        else
        begin
            v_clamp = v_pre[V_W-1:0];
        end
    end
    assign t_mul       = (T_W'(v_clamp) <<< 15) - T_W'(v_clamp);
    assign t_bias      = t_mul[T_W-1] ? (t_mul + ROUND_BIAS) : t_mul;
    assign t_quot      = t_bias >>> 23;
    assign sample_next = t_quot[stbg_pkg::SAMPLE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= '0;
            in_hist_one_reg  <= '0;
            in_hist_two_reg  <= '0;
            out_hist_one_reg <= '0;
            out_hist_two_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.accept && restart)
            begin
                phase_reg        <= '0;
                in_hist_one_reg  <= '0;
                in_hist_two_reg  <= '0;
                out_hist_one_reg <= '0;
                out_hist_two_reg <= '0;
            end
            if (cmd.lookup && (cfg.phase_step != '0))
            begin
                phase_reg <= phase_reg + {1'b0, cfg.phase_step};
            end
            if (cmd.filt)
            begin
                in_hist_two_reg  <= in_hist_one_reg;
                in_hist_one_reg  <= x_reg;
                out_hist_two_reg <= out_hist_one_reg;
                out_hist_one_reg <= y_sat;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.lookup)
        begin
            entry_reg   <= stbg_pkg::SINE_LUT[idx];
            neg_reg     <= phase_reg[stbg_pkg::PHASE_W-1];
            tone_on_reg <= (cfg.phase_step != '0);
        end
        if (cmd.make_x)
        begin
            x_reg <= x_next;
        end
        case (cmd.acc_op)
            stbg_pkg::ACC_CLEAR: acc_reg <= '0;
            stbg_pkg::ACC_ADD:   acc_reg <= acc_reg + prod_ext;
            stbg_pkg::ACC_SUB:   acc_reg <= acc_reg - prod_ext;
            default:             acc_reg <= acc_reg;
        endcase
        if (cmd.load_out)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sts.eq_on    = cfg.eq_enable;
    assign sts.out_busy = out_valid_reg && out_stall;
    assign out_valid    = out_valid_reg;
    assign sample       = sample_reg;

endmodule

@@ rtl/sine_tone_biquad_generator.sv @@
// ============================================================================
// sine_tone_biquad_generator
// Phase-accumulator sine tone with optional direct-form-I biquad filter.
// ============================================================================
// Input channel: in_valid / in_stall carry one sample tick; restart set on a
// beat clears the phase and filter history before that sample is made.
// Output channel: out_valid / out_stall carry one signed 16-bit sample per
// input beat, meant for both audio channels.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; the
// registers are phase step, amplitude, filter enable and b0, b1, b2, a1, a2.
// cfg_ready is always high; write only while no sample is in flight.
// Steps: table lookup, tone scaling, filter input, the filter when on, output
// scaling. One sample is worked on at a time; a new beat is taken once the last
// is in the output register. The five filter products share one multiplier.
// The finished sample sits in an output register, so the next beat is taken
// while it waits. When out_stall is high the sample holds; if a second sample
// is finished before the first leaves, the sequencer holds until it does.
// Reset clears phase, history and the output valid flag and loads the default
// register values (amplitude 29196, b0 = 1.0).
// ============================================================================
module sine_tone_biquad_generator (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 restart,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [stbg_pkg::SAMPLE_W-1:0] sample,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [stbg_pkg::IDX_W-1:0]           cfg_index,
    input  logic [stbg_pkg::COEF_W-1:0]          cfg_data
);

    stbg_pkg::cfg_t cfg;
    stbg_pkg::cmd_t cmd;
    stbg_pkg::sts_t sts;

    stbg_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    stbg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    stbg_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd       (cmd),
        .sts       (sts),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample)
    );

endmodule

@@ rtl/stbg_checker.sv @@
// ============================================================================
// stbg_checker
// Port-level checks for the sine tone generator, bound to the top level.
// ============================================================================
module stbg_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [stbg_pkg::SAMPLE_W-1:0] sample
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample))
        else $error("output beat changed while stalled");

    // the most negative code is never produced
    a_no_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample != 16'sh8000)
        else $error("sample outside +/-32767");

    // one sample in flight: stall right after a beat is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second beat taken while busy");

    // no output beat appears straight after an input beat
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("output beat too soon after input beat");

endmodule

bind sine_tone_biquad_generator stbg_checker u_stbg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample)
);
